// ===== hw/rtl/yipd_pkg.sv =====
// Package for the YUV pyramid downscaler: sizes, register indexes, shared types.
// No dependencies.
`timescale 1ns / 1ps
package yipd_pkg;
  localparam int MaxWidth  = 2048;
  localparam int MaxHeight = 2048;
  localparam int MaxLevels = 4;
  localparam int HalfW     = MaxWidth / 2;
  localparam int HalfAw    = $clog2(HalfW);
  localparam int QDepth    = 4;

  localparam logic [1:0] RegWidth  = 2'd0;
  localparam logic [1:0] RegHeight = 2'd1;
  localparam logic [1:0] RegLevels = 2'd2;

  // word handed from the front to the averaging back end
  typedef struct packed {
    logic [7:0] data;
  } in_word_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } out_word_t;

  // effective geometry, settled at config time
  typedef struct packed {
    logic [11:0] width;
    logic [11:0] height;
    logic [2:0]  nlev;
    logic        empty;
  } geom_t;
endpackage

// ===== hw/rtl/yipd_if.sv =====
// Valid/ready stream interface for input and output, and the config interface.
// Depends on nothing.
`timescale 1ns / 1ps
interface yipd_stream_if #(parameter int W = 8);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface yipd_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [11:0] wdata;
  modport source (output valid, output index, output wdata, input ready);
  modport sink   (input valid, input index, input wdata, output ready);
endinterface

// ===== hw/rtl/yipd_ram.sv =====
// Generic single-write, single-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module yipd_ram #(
  parameter int Width = 10,
  parameter int Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    if (re_i) rdata_o <= mem_q[raddr_i];
  end
endmodule

// ===== hw/rtl/yipd_fifo.sv =====
// Short queue decoupling the front from the back end.
// Depends on yipd_pkg.
`timescale 1ns / 1ps
module yipd_fifo
  import yipd_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  in_word_t wdata_i,
  output logic     full_o,
  input  logic     pop_i,
  output in_word_t rdata_o,
  output logic     empty_o
);
  localparam int Aw = $clog2(QDepth);
  in_word_t       mem_q [QDepth];
  logic [Aw-1:0]  wp_q, rp_q;
  logic [Aw:0]    cnt_q;

  assign full_o  = (cnt_q == (Aw+1)'(QDepth));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= wdata_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= wp_q + 1'b1;
      if (pop_i)  rp_q <= rp_q + 1'b1;
      cnt_q <= cnt_q + (Aw+1)'(push_i) - (Aw+1)'(pop_i);
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o && !pop_i |-> !push_i) else $error("fifo overflow");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_o |-> !pop_i) else $error("fifo underflow");
  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (Aw+1)'(QDepth)) else $error("fifo count out of range");
`endif
endmodule

// ===== hw/rtl/yipd_back.sv =====
// Back end: a cascade of 2x2 box-filter stages, one byte per cycle per level when not stalled.
// Depends on yipd_pkg and yipd_ram.
`timescale 1ns / 1ps
module yipd_back
  import yipd_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  geom_t     geom_i,
  input  logic      clear_i,
  input  logic      in_valid_i,
  input  in_word_t  in_word_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  output out_word_t out_word_o,
  input  logic      out_ready_i
);
  // Each stage k has a pipeline slot: v_q[k] (word valid entering stage k).
  // Stage k has one register stage (classify + RAM read); the combine that
  // follows feeds stage k+1 in the same cycle.
  logic [MaxLevels:0]   v_q;
  logic [7:0]           x_q [MaxLevels+1];
  logic [MaxLevels-1:0] a_v_q;
  logic [9:0]           a_pair_q [MaxLevels];
  logic [MaxLevels-1:0] a_odd_q, a_last_q;
  logic [9:0]           left_q [MaxLevels];
  logic [10:0]          col_q [MaxLevels];
  logic [11:0]          row_q [MaxLevels];
  logic [9:0]           rdat [MaxLevels];
  logic                 adv;

  // the whole cascade advances together; it stalls only when the output
  // register is full and not taken
  logic out_full_q;
  out_word_t out_q;
  logic fin_v;
  assign adv        = !out_full_q || out_ready_i;
  assign in_ready_o = adv;
  assign out_valid_o = out_full_q;
  assign out_word_o  = out_q;

  assign x_q[0] = in_word_i.data;
  assign v_q[0] = in_valid_i && !geom_i.empty;

  for (genvar k = 0; k < MaxLevels; k++) begin : g_stage
    logic [11:0] w, h, hc, tot, lr, prow;
    logic [10:0] wn, hn;
    logic        luma, take, odd_c, odd_r, active, lastv;
    logic [9:0]  pair;
    logic [11:0] orow;
    logic [HalfAw-1:0] ci;
    logic [11:0] c12;

    assign active = (3'(k) < geom_i.nlev);
    assign w    = geom_i.width >> k;
    assign h    = geom_i.height >> k;
    assign hc   = h >> 1;
    assign tot  = h + hc;
    assign c12  = {1'b0, col_q[k]};
    assign luma = row_q[k] < h;
    assign lr   = luma ? row_q[k] : row_q[k] - h;
    assign prow = luma ? h : hc;
    assign take = (c12 < {w[11:1], 1'b0}) && (lr < {prow[11:1], 1'b0});
    assign odd_c = col_q[k][0];
    assign odd_r = lr[0];
    assign pair  = left_q[k] + {2'b0, x_q[k]};
    assign ci    = col_q[k][HalfAw:1];
    assign wn    = w[11:1];
    assign hn    = h[11:1];
    assign orow  = luma ? {1'b0, lr[11:1]} : {1'b0, hn} + {1'b0, lr[11:1]};
    assign lastv = (3'(k + 1) == geom_i.nlev) && ({1'b0, ci} == wn - 11'd1) &&
                   (orow + 12'd1 == {1'b0, hn} + {2'b0, hn[10:1]});

    logic fire;
    assign fire = adv && v_q[k] && active;

    yipd_ram #(.Width(10), .Depth(HalfW)) u_ram (
      .clk_i  (clk_i),
      .we_i   (fire && take && odd_c && !odd_r),
      .waddr_i(ci),
      .wdata_i(pair),
      .re_i   (fire),
      .raddr_i(ci),
      .rdata_o(rdat[k])
    );

    // counters and left byte
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        col_q[k] <= '0; row_q[k] <= '0; left_q[k] <= '0;
        a_v_q[k] <= 1'b0;
      end else if (clear_i) begin
        col_q[k] <= '0; row_q[k] <= '0; left_q[k] <= '0;
        a_v_q[k] <= 1'b0;
      end else if (adv) begin
        a_v_q[k] <= fire && take && odd_c && odd_r;
        if (fire) begin
          if (take && !odd_c) left_q[k] <= {2'b0, x_q[k]};
          if (c12 + 12'd1 >= w) begin
            col_q[k] <= '0;
            row_q[k] <= (row_q[k] + 12'd1 >= tot) ? 12'd0 : row_q[k] + 12'd1;
          end else begin
            col_q[k] <= col_q[k] + 11'd1;
          end
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        a_pair_q[k] <= pair;
        a_last_q[k] <= lastv;
        a_odd_q[k]  <= odd_r;
      end
    end

    // combine with the stored pair sum of the even row
    logic [10:0] tot4;
    assign tot4 = {1'b0, rdat[k]} + {1'b0, a_pair_q[k]};
    assign x_q[k+1] = tot4[9:2];
    assign v_q[k+1] = a_v_q[k] && (3'(k + 1) < geom_i.nlev);
  end

  // pick the final stage's product
  logic [7:0] fin_d;
  logic       fin_l;
  always_comb begin
    fin_v = 1'b0; fin_d = '0; fin_l = 1'b0;
    for (int k = 0; k < MaxLevels; k++) begin
      if (3'(k + 1) == geom_i.nlev) begin
        fin_v = a_v_q[k]; fin_d = x_q[k+1]; fin_l = a_last_q[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_full_q <= 1'b0;
    else if (adv) out_full_q <= fin_v;
  end
  always_ff @(posedge clk_i) begin
    if (adv) out_q <= '{data: fin_d, last: fin_l};
  end

`ifndef SYNTHESIS
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_full_q && !out_ready_i |=> out_full_q && $stable(out_q))
    else $error("output lost while stalled");
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |-> !in_ready_o) else $error("accept during stall");
  a_ram: assert property (@(posedge clk_i) disable iff (!rst_ni)
    a_v_q[0] |-> !a_odd_q[0] == 1'b0) else $error("combine on even row");
`endif
endmodule

// ===== hw/rtl/yipd_front.sv =====
// Front: config registers, geometry decode, input acceptance into the queue.
// Depends on yipd_pkg.
`timescale 1ns / 1ps
module yipd_front
  import yipd_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     cfg_valid_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [11:0] cfg_wdata_i,
  input  logic     in_valid_i,
  input  logic [7:0] in_data_i,
  output logic     in_ready_o,
  input  logic     q_full_i,
  output logic     push_o,
  output in_word_t push_word_o,
  output geom_t    geom_o,
  output logic     clear_o
);
  logic [11:0] width_q, height_q;
  logic [2:0]  levels_q;
  logic        known;

  assign known = (cfg_index_i == RegWidth) || (cfg_index_i == RegHeight) ||
                 (cfg_index_i == RegLevels);
  assign clear_o = cfg_valid_i && known;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= 12'd640; height_q <= 12'd480; levels_q <= 3'd1;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegWidth:  width_q  <= cfg_wdata_i;
        RegHeight: height_q <= cfg_wdata_i;
        RegLevels: levels_q <= cfg_wdata_i[2:0];
        default: ;
      endcase
    end
  end

  // clamp to supported sizes
  always_comb begin
    geom_o.width  = (width_q > 12'(MaxWidth - 1)) ? 12'(MaxWidth - 1) + 12'd1 : width_q;
    geom_o.height = (height_q > 12'(MaxHeight - 1)) ? 12'(MaxHeight - 1) + 12'd1 : height_q;
    geom_o.nlev   = (levels_q == 3'd0) ? 3'd1 :
                    (levels_q > 3'(MaxLevels)) ? 3'(MaxLevels) : levels_q;
    geom_o.empty  = (width_q == 12'd0) || (height_q == 12'd0);
  end

  assign in_ready_o       = !q_full_i && !cfg_valid_i;
  assign push_o           = in_valid_i && in_ready_o;
  assign push_word_o.data = in_data_i;

`ifndef SYNTHESIS
  a_lev: assert property (@(posedge clk_i) disable iff (!rst_ni)
    geom_o.nlev != 3'd0) else $error("zero levels");
  a_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> !q_full_i) else $error("push into full queue");
  a_cfg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> !push_o) else $error("byte taken during config");
`endif
endmodule

// ===== hw/rtl/yuv_image_pyramid_downscale.sv =====
// Top level of the YUV pyramid downscaler.
// Depends on yipd_pkg, yipd_if, yipd_front, yipd_fifo, yipd_back.
//
// Usage:
//   in_if   : frame bytes, luma plane then chroma plane, raster order.
//   out_if  : bytes of the final level {data, last}; last marks frame end.
//   cfg_if  : register writes (0 width, 1 height, 2 levels); each write to one of
//             these restarts frame counting with the next byte. Write only idle.
// Throughput: one input byte per cycle unless the output stalls or a config
// write is valid; each level stage holds one line of pair sums in its own RAM.
// Path: the queue, one register stage per level, then the output register.
// Reset: counters cleared, registers 640x480, one level; the pair-sum RAM is
// not cleared (every entry is written on an even row before it is read).
// Stall: when the receiver holds ready low, the output register keeps its
// word, the stage cascade freezes, and the queue fills before input ready
// drops.
`timescale 1ns / 1ps
module yuv_image_pyramid_downscale
  import yipd_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  yipd_stream_if.sink   in_if,
  yipd_stream_if.source out_if,
  yipd_cfg_if.sink      cfg_if
);
  logic      q_full, q_empty, push, pop, back_ready, clear;
  in_word_t  push_word, q_word;
  geom_t     geom;
  out_word_t ow;

  assign cfg_if.ready = 1'b1;

  yipd_front u_front (
    .clk_i, .rst_ni,
    .cfg_valid_i(cfg_if.valid), .cfg_index_i(cfg_if.index),
    .cfg_wdata_i(cfg_if.wdata),
    .in_valid_i(in_if.valid), .in_data_i(in_if.data[7:0]),
    .in_ready_o(in_if.ready),
    .q_full_i(q_full), .push_o(push), .push_word_o(push_word),
    .geom_o(geom), .clear_o(clear)
  );

  yipd_fifo u_fifo (
    .clk_i, .rst_ni,
    .push_i(push), .wdata_i(push_word), .full_o(q_full),
    .pop_i(pop), .rdata_o(q_word), .empty_o(q_empty)
  );

  assign pop = !q_empty && back_ready;

  yipd_back u_back (
    .clk_i, .rst_ni, .geom_i(geom), .clear_i(clear),
    .in_valid_i(!q_empty), .in_word_i(q_word), .in_ready_o(back_ready),
    .out_valid_o(out_if.valid), .out_word_o(ow), .out_ready_i(out_if.ready)
  );

  assign out_if.data = {ow.data, ow.last};

`ifndef SYNTHESIS
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && !out_if.ready |=> out_if.valid) else $error("valid dropped");
  a_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_empty) else $error("pop from empty queue");
  a_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_if.ready |-> !q_full) else $error("ready with full queue");
`endif
endmodule
